// ===== rtl/hdsc_pkg.sv =====
// Shared widths, constants and constant tables for the Hamming single-error decoder.
package hdsc_pkg;

  localparam int unsigned MaxLength = 63;
  localparam int unsigned PosW      = 6;
  localparam int unsigned DataW     = 57;
  localparam int unsigned CntW      = 6;
  localparam logic [PosW-1:0] LengthReset = 6'd7;

  typedef logic [MaxLength-1:0] word_t;
  typedef logic [DataW-1:0]     data_t;
  typedef logic [PosW-1:0]      pos_t;
  typedef logic [CntW-1:0]      cnt_t;

  // Codeword bits that feed syndrome bit j: positions whose number has bit j set.
  function automatic word_t syn_mask(input int j);
    word_t m;
    m = '0;
    for (int k = 0; k < MaxLength; k++) begin
      m[k] = 1'(((k + 1) >> j) & 1);
    end
    return m;
  endfunction

  // Codeword bit index that holds data bit i (skip power-of-two positions).
  function automatic pos_t data_src(input int i);
    int   cnt;
    pos_t src;
    cnt = 0;
    src = '0;
    for (int p = 1; p <= MaxLength; p++) begin
      if ((p & (p - 1)) != 0) begin
        if (cnt == i) begin
          src = pos_t'(p - 1);
        end
        cnt++;
      end
    end
    return src;
  endfunction

endpackage

// ===== rtl/hdsc_if.sv =====
// Channel interfaces: codeword input, decoded result output and length configuration.
interface hdsc_in_if;
  logic                 valid;
  logic                 ready;
  hdsc_pkg::word_t      codeword;
  modport source (output valid, output codeword, input ready);
  modport sink   (input valid, input codeword, output ready);
endinterface

interface hdsc_out_if;
  logic                 valid;
  logic                 ready;
  hdsc_pkg::data_t      data_bits;
  hdsc_pkg::cnt_t       data_count;
  hdsc_pkg::pos_t       error_position;
  logic                 error_corrected;
  logic                 syndrome_invalid;
  modport source (output valid, output data_bits, output data_count, output error_position,
                  output error_corrected, output syndrome_invalid, input ready);
  modport sink   (input valid, input data_bits, input data_count, input error_position,
                  input error_corrected, input syndrome_invalid, output ready);
endinterface

interface hdsc_cfg_if;
  logic                 valid;
  logic                 ready;
  hdsc_pkg::pos_t       code_length;
  modport source (output valid, output code_length, input ready);
  modport sink   (input valid, input code_length, output ready);
endinterface

// ===== rtl/hamming_decoder_single_correct_unit.sv =====
// Hamming single-error-correcting decoder: top level with input and result registers.
// Decodes one Hamming codeword per item. Codeword bit 0 is position 1 and parity
// bits sit at power-of-two positions; the codeword length (0..63, reset 7) comes
// from the configuration channel and is sampled with each item, so a write only
// affects items accepted after it. Each item passes an input register, then one
// short combinational pass (masking, six XOR parity trees for the syndrome, a
// one-hot bit flip and fixed-wiring data extraction) into the result register.
// The item passes the input register, then the result register, from which it
// leaves; throughput is one item per cycle while out_ch.ready holds, set by the
// two-register pipeline. While a finished result waits on out_ch.ready the input
// register takes one more item, then in_ch.ready drops until the result drains. A
// syndrome above the length is reported with syndrome_invalid and the data pass
// through uncorrected. The configuration channel is always ready.
module hamming_decoder_single_correct_unit (
  input  logic        clk,
  input  logic        rst_n,
  hdsc_in_if.sink     in_ch,
  hdsc_out_if.source  out_ch,
  hdsc_cfg_if.sink    cfg_ch
);

  // Configuration register
  hdsc_pkg::pos_t  len_r;

  // Input stage: raw codeword plus the length it is decoded with
  logic            s1_v_r;
  hdsc_pkg::word_t s1_word_r;
  hdsc_pkg::pos_t  s1_len_r;

  // Result stage
  logic            s2_v_r;
  hdsc_pkg::data_t s2_data_r;
  hdsc_pkg::cnt_t  s2_cnt_r;
  hdsc_pkg::pos_t  s2_syn_r;
  logic            s2_corr_r;
  logic            s2_inv_r;

  // Decode results
  hdsc_pkg::word_t word_msk;
  hdsc_pkg::word_t word_fix;
  hdsc_pkg::pos_t  syn_nxt;
  hdsc_pkg::data_t data_nxt;
  hdsc_pkg::cnt_t  cnt_nxt;
  logic [2:0]      pow_cnt;
  logic            inv_nxt;
  logic            corr_nxt;

  logic            s2_load;
  logic            s1_load;

  // Handshake: result stage takes a new item when empty or draining;
  // input stage takes one when empty or moving forward.
  assign s2_load      = !s2_v_r || out_ch.ready;
  assign in_ch.ready  = !s1_v_r || s2_load;
  assign s1_load      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= hdsc_pkg::LengthReset;
    end else if (cfg_ch.valid) begin
      len_r <= cfg_ch.code_length;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_v_r <= in_ch.valid;
    end
  end

  // Capture the payload with the length in force at acceptance
  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_word_r <= in_ch.codeword;
      s1_len_r  <= len_r;
    end
  end

  always_comb begin
    // Drop bits beyond the configured length
    for (int k = 0; k < hdsc_pkg::MaxLength; k++) begin
      word_msk[k] = (k < int'(s1_len_r)) ? s1_word_r[k] : 1'b0;
    end

    // Syndrome: XOR of the position numbers of all set bits, one parity tree per bit
    for (int j = 0; j < hdsc_pkg::PosW; j++) begin
      syn_nxt[j] = ^(word_msk & hdsc_pkg::syn_mask(j));
    end

    inv_nxt  = syn_nxt > s1_len_r;
    corr_nxt = (syn_nxt != '0) && !inv_nxt;

    // Flip the named bit; no bit when the syndrome is zero or out of range
    for (int k = 0; k < hdsc_pkg::MaxLength; k++) begin
      word_fix[k] = word_msk[k] ^ (corr_nxt && (syn_nxt == hdsc_pkg::pos_t'(k + 1)));
    end

    // Pack data positions; masked bits above the length come out as zero
    for (int i = 0; i < hdsc_pkg::DataW; i++) begin
      data_nxt[i] = word_fix[hdsc_pkg::data_src(i)];
    end

    // Parity positions within the length: one per power of two not above it
    case (s1_len_r) inside
      6'd0:        pow_cnt = 3'd0;
      6'd1:        pow_cnt = 3'd1;
      [6'd2:6'd3]:   pow_cnt = 3'd2;
      [6'd4:6'd7]:   pow_cnt = 3'd3;
      [6'd8:6'd15]:  pow_cnt = 3'd4;
      [6'd16:6'd31]: pow_cnt = 3'd5;
      default:     pow_cnt = 3'd6;
    endcase
    cnt_nxt = s1_len_r - {3'b000, pow_cnt};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_load) begin
      s2_v_r <= s1_v_r;
    end
  end

  // Advance the decoded item into the result register
  always_ff @(posedge clk) begin
    if (s2_load && s1_v_r) begin
      s2_data_r <= data_nxt;
      s2_cnt_r  <= cnt_nxt;
      s2_syn_r  <= syn_nxt;
      s2_corr_r <= corr_nxt;
      s2_inv_r  <= inv_nxt;
    end
  end

  assign out_ch.valid            = s2_v_r;
  assign out_ch.data_bits        = s2_data_r;
  assign out_ch.data_count       = s2_cnt_r;
  assign out_ch.error_position   = s2_syn_r;
  assign out_ch.error_corrected  = s2_corr_r;
  assign out_ch.syndrome_invalid = s2_inv_r;

  // A decoded item moving forward lands in the result register
  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && s2_load) |=> s2_v_r)
    else $error("decoded item lost between stages");

  // A correction never coexists with an out-of-range syndrome
  a_corr_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !(out_ch.error_corrected && out_ch.syndrome_invalid))
    else $error("corrected and invalid both set");

  // A correction needs a nonzero syndrome
  a_corr_syn: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.error_corrected) |-> (out_ch.error_position != '0))
    else $error("correction with zero syndrome");

  // Data count never exceeds the data field width
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.data_count <= hdsc_pkg::cnt_t'(hdsc_pkg::DataW)))
    else $error("data count out of range");

endmodule
